### rtl/toy_feistel_byte_cipher_assert.svh
// Assertion macros for the byte cipher checker
`ifndef TOY_FEISTEL_BYTE_CIPHER_ASSERT_SVH
`define TOY_FEISTEL_BYTE_CIPHER_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define TFBC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define TFBC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/tfbc_pkg.sv
// Shared types, constants and round function for the byte cipher
package tfbc_pkg;

   localparam int NUM_ROUNDS = 4;
   localparam int KEY_W      = 6;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_KEY0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MODE = 3'd4;

   localparam logic [3:0] SBOX1 [4][16] = '{
      '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
        4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7},
      '{4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
        4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8},
      '{4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
        4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0},
      '{4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
        4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13}
   };

   typedef struct packed {
      logic [NUM_ROUNDS-1:0][KEY_W-1:0] round_key;
      logic                             decrypt_mode;
   } cfg_type;

   function automatic logic [7:0] feistel_round(logic [7:0] din, logic [KEY_W-1:0] key);
      logic [3:0]       left;
      logic [3:0]       right;
      logic [KEY_W-1:0] expd;
      logic [1:0]       row;
      logic [3:0]       col;
      logic [3:0]       sout;
      logic [3:0]       fval;
      left  = din[7:4];
      right = din[3:0];
      expd  = {right[2], right[3], right[2], right[1], right[0], right[1]} ^ key;
      row   = {expd[5], expd[0]};
      col   = expd[4:1];
      sout  = SBOX1[row][col];
      fval  = {sout[2], sout[0], sout[3], sout[1]};
      return {right, left ^ fval};
   endfunction

endpackage

### rtl/tfbc_if.sv
// Valid/ready channel interfaces for input and result words
interface tfbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface tfbc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] result_byte;
   modport source (output valid, output result_byte, input ready);
   modport sink   (input valid, input result_byte, output ready);
endinterface

### rtl/toy_feistel_byte_cipher.sv
// Throughput: one word per cycle; a stalled output holds words in the round stages.
// Each of the four round stages is a register, the last one doubling as output register.
// Reset (synchronous, active high) empties the stages and clears keys and mode to zero.
// Top level of the four-round byte cipher
module toy_feistel_byte_cipher import tfbc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tfbc_req_if.sink              req_if,
   tfbc_rsp_if.source            rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type                          cfg;
   logic [NUM_ROUNDS:0]              link_valid;
   logic [NUM_ROUNDS:0]              link_ready;
   logic [NUM_ROUNDS:0][7:0]         link_byte;
   logic [NUM_ROUNDS-1:0][KEY_W-1:0] cell_key;

   tfbc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign link_valid[0] = req_if.valid;
   assign link_byte[0]  = req_if.data_byte;
   assign req_if.ready  = link_ready[0];

   for (genvar j = 0; j < NUM_ROUNDS; j++) begin : g_cell
      assign cell_key[j] = cfg.decrypt_mode ? cfg.round_key[NUM_ROUNDS-1-j]
                                            : cfg.round_key[j];
      tfbc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[j]),
         .in_ready  (link_ready[j]),
         .in_byte   (link_byte[j]),
         .round_key (cell_key[j]),
         .out_valid (link_valid[j+1]),
         .out_ready (link_ready[j+1]),
         .out_byte  (link_byte[j+1])
      );
   end

   assign rsp_if.valid       = link_valid[NUM_ROUNDS];
   assign link_ready[NUM_ROUNDS] = rsp_if.ready;
   assign rsp_if.result_byte = {link_byte[NUM_ROUNDS][3:0], link_byte[NUM_ROUNDS][7:4]};

endmodule

### rtl/tfbc_csr.sv
// APB-style configuration registers: round keys and mode
module tfbc_csr import tfbc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [NUM_ROUNDS-1:0][KEY_W-1:0] key_ff, key_in;
   logic                             mode_ff, mode_in;
   logic [CSR_IDX_W-1:0]             idx;
   logic                             wr_en;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      key_in  = key_ff;
      mode_in = mode_ff;
      if (wr_en) begin
         unique case (idx)
            REG_KEY0: key_in[0] = csr_pwdata[KEY_W-1:0];
            REG_KEY1: key_in[1] = csr_pwdata[KEY_W-1:0];
            REG_KEY2: key_in[2] = csr_pwdata[KEY_W-1:0];
            REG_KEY3: key_in[3] = csr_pwdata[KEY_W-1:0];
            REG_MODE: mode_in   = csr_pwdata[0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_KEY0: csr_prdata = {{(32-KEY_W){1'b0}}, key_ff[0]};
         REG_KEY1: csr_prdata = {{(32-KEY_W){1'b0}}, key_ff[1]};
         REG_KEY2: csr_prdata = {{(32-KEY_W){1'b0}}, key_ff[2]};
         REG_KEY3: csr_prdata = {{(32-KEY_W){1'b0}}, key_ff[3]};
         REG_MODE: csr_prdata = {31'd0, mode_ff};
         default:  csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         mode_ff <= 1'b0;
      end else begin
         key_ff  <= key_in;
         mode_ff <= mode_in;
      end
   end

   assign cfg.round_key    = key_ff;
   assign cfg.decrypt_mode = mode_ff;

endmodule

### rtl/tfbc_cell.sv
// One Feistel round stage with its own valid/ready hop
module tfbc_cell import tfbc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [7:0]       in_byte,
   input  logic [KEY_W-1:0] round_key,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [7:0]       out_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
      byte_in  = (in_ready && in_valid) ? feistel_round(in_byte, round_key) : byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;

endmodule

### rtl/tfbc_checker.sv
// Port-level checker for the byte cipher, bound to the top level
`include "toy_feistel_byte_cipher_assert.svh"

module tfbc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_result_byte
);

   logic [7:0] rsp_seen;

   assign rsp_seen = rsp_result_byte;

   `TFBC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_seen), "stalled result word dropped or changed")

   `TFBC_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_valid, "result valid right after reset")

   `TFBC_ASSERT_NOW(a_ready_flow, rsp_ready, req_ready, "input stalled while output drains")

   `TFBC_ASSERT_NEXT(a_latency, (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready, rsp_valid, "word not out four cycles after accept")

endmodule

bind toy_feistel_byte_cipher tfbc_checker u_tfbc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_result_byte (rsp_if.result_byte)
);

### dv/toy_feistel_byte_cipher_checker.sv
// Checker for the byte cipher: tracks key writes, predicts each result word and compares
`timescale 1ns / 1ps

module toy_feistel_byte_cipher_checker import tfbc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tfbc_req_if                   req_if,
   tfbc_rsp_if                   rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output int                    fail_count,
   output int                    outstanding
);

   localparam logic [3:0] S1_BOX [4][16] = '{
      '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
        4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7},
      '{4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
        4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8},
      '{4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
        4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0},
      '{4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
        4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13}
   };

   logic [KEY_W-1:0] subkey [NUM_ROUNDS];
   logic             decrypting;
   logic [7:0]       cipher_expect [$];
   int               mismatches;

   function automatic logic [7:0] cipher_byte(logic [7:0] din,
                                              logic [KEY_W-1:0] keys [NUM_ROUNDS],
                                              logic dec);
      logic [7:0]       word;
      logic [3:0]       lh;
      logic [3:0]       rh;
      logic [KEY_W-1:0] mixed;
      logic [3:0]       sval;
      logic [KEY_W-1:0] k;
      word = din;
      for (int r = 0; r < NUM_ROUNDS; r++) begin
         k     = dec ? keys[NUM_ROUNDS-1-r] : keys[r];
         lh    = word[7:4];
         rh    = word[3:0];
         mixed = {rh[2], rh[3], rh[2], rh[1], rh[0], rh[1]} ^ k;
         sval  = S1_BOX[{mixed[5], mixed[0]}][mixed[4:1]];
         word  = {rh, lh ^ {sval[2], sval[0], sval[3], sval[1]}};
      end
      return {word[3:0], word[7:4]};
   endfunction

   always @(posedge clock) begin
      logic [CSR_IDX_W-1:0] idx;
      logic [7:0]           want;
      if (reset) begin
         for (int i = 0; i < NUM_ROUNDS; i++) subkey[i] = '0;
         decrypting = 1'b0;
         cipher_expect.delete();
         mismatches = 0;
      end else begin
         if (req_if.valid && req_if.ready)
            cipher_expect.push_back(cipher_byte(req_if.data_byte, subkey, decrypting));
         if (rsp_if.valid && rsp_if.ready) begin
            if (cipher_expect.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result word %02h", $time, rsp_if.result_byte);
            end else begin
               want = cipher_expect.pop_front();
               if (rsp_if.result_byte !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: result_byte mismatch: expected %02h got %02h",
                              $time, want, rsp_if.result_byte);
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            idx = csr_paddr[CSR_ADDR_W-1:2];
            case (idx)
               REG_KEY0: subkey[0] = csr_pwdata[KEY_W-1:0];
               REG_KEY1: subkey[1] = csr_pwdata[KEY_W-1:0];
               REG_KEY2: subkey[2] = csr_pwdata[KEY_W-1:0];
               REG_KEY3: subkey[3] = csr_pwdata[KEY_W-1:0];
               REG_MODE: decrypting = csr_pwdata[0];
               default: ;
            endcase
         end
      end
      fail_count  <= mismatches;
      outstanding <= cipher_expect.size();
   end

endmodule

### dv/toy_feistel_byte_cipher_tb.sv
// Top of the byte cipher testbench: clock, reset, key writes, input words and verdict
`timescale 1ns / 1ps

module toy_feistel_byte_cipher_tb;
   import tfbc_pkg::*;

   localparam int NUM_PHASES      = 10;
   localparam int WORDS_PER_PHASE = 188;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    outstanding;
   bit                    calm;
   int                    idle_pct;

   tfbc_req_if req_bus ();
   tfbc_rsp_if rsp_bus ();

   toy_feistel_byte_cipher dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   toy_feistel_byte_cipher_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left == 0 && !calm && idle_pct > 0 && $urandom_range(1, 100) <= idle_pct)
            stall_left = $urandom_range(1, 10);
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_word(input logic [7:0] b);
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      if (!calm && idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic drain_words();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
   endtask

   task automatic load_keys(input logic [KEY_W-1:0] k0, input logic [KEY_W-1:0] k1,
                            input logic [KEY_W-1:0] k2, input logic [KEY_W-1:0] k3,
                            input logic dec);
      csr_write(REG_KEY0, ($urandom() & ~32'h3f) | 32'(k0));
      csr_write(REG_KEY1, ($urandom() & ~32'h3f) | 32'(k1));
      csr_write(REG_KEY2, ($urandom() & ~32'h3f) | 32'(k2));
      csr_write(REG_KEY3, ($urandom() & ~32'h3f) | 32'(k3));
      csr_write(REG_MODE, ($urandom() & ~32'h1) | 32'(dec));
      for (int i = REG_MODE + 1; i < (1 << CSR_IDX_W); i++)
         csr_write(CSR_IDX_W'(i), $urandom());
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin
      logic [7:0] directed [$];
      logic [7:0] b;
      reset             = 1'b1;
      calm              = 1'b0;
      idle_pct          = 20;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed = '{8'h00, 8'hff, 8'h0f, 8'hf0, 8'h55, 8'haa, 8'h00, 8'h01, 8'h02, 8'h04,
                   8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h7f, 8'h00, 8'hfe, 8'h3c, 8'hc3};
      foreach (directed[i]) send_word(directed[i]);
      drain_words();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: load_keys(6'h3f, 6'h3f, 6'h3f, 6'h3f, 1'b0);
            1: load_keys(6'h3f, 6'h3f, 6'h3f, 6'h3f, 1'b1);
            2: load_keys(6'h00, 6'h00, 6'h00, 6'h00, 1'b1);
            3: load_keys(6'h2a, 6'h15, 6'h3f, 6'h00, 1'b0);
            default: load_keys(KEY_W'($urandom()), KEY_W'($urandom()),
                               KEY_W'($urandom()), KEY_W'($urandom()), p[0]);
         endcase
         case (p % 3)
            0: idle_pct = 0;
            1: idle_pct = 10;
            default: idle_pct = 35;
         endcase
         if (p == NUM_PHASES - 1) calm = 1'b1;
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            case ($urandom_range(0, 15))
               0: b = 8'h00;
               1: b = 8'hff;
               default: b = 8'($urandom_range(0, 255));
            endcase
            send_word(b);
         end
         drain_words();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/tfbc_pkg.sv
rtl/tfbc_if.sv
rtl/tfbc_csr.sv
rtl/tfbc_cell.sv
rtl/toy_feistel_byte_cipher.sv
rtl/tfbc_checker.sv
dv/toy_feistel_byte_cipher_checker.sv
dv/toy_feistel_byte_cipher_tb.sv
